/* design/etsu_pkg.sv */
// Shared constants, types and codes for the scope edge trigger search unit.
package etsu_pkg;

    localparam int BUFFER_DEPTH = 2048;
    localparam int SAMPLE_BITS  = 12;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = ADDR_W + 1;
    localparam int HALF_STEPS   = BUFFER_DEPTH / 2;
    localparam int STEP_W       = $clog2(HALF_STEPS);

    localparam int LEVEL_W      = 12;
    localparam int VHW_W        = 10;
    localparam int INDEX_W      = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(2048);
    localparam logic [VHW_W-1:0]   VHW_RESET   = VHW_W'(64);

    typedef enum logic {
        CMD_STORE  = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER_LEVEL   = 2'd0,
        REG_FALLING_EDGE    = 2'd1,
        REG_VIEW_HALF_WIDTH = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FIRST = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_HOLD  = 4'b1000
    } t_back_state;

    // One classified command waiting for the back end.
    typedef struct packed {
        logic                   search;
        logic [ADDR_W-1:0]      addr;
        logic [SAMPLE_BITS-1:0] sample;
    } t_cmd;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               falling;
    } t_trig_cfg;

    typedef struct packed {
        logic [INDEX_W-1:0] trigger_index;
        logic               found;
    } t_result;

endpackage

/* design/etsu_in_if.sv */
// Command channel interface: valid/ready handshake with cmd and sample payload.
interface etsu_in_if;
    logic                            valid;
    logic                            ready;
    logic                            cmd;
    logic [etsu_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

/* design/etsu_out_if.sv */
// Result channel interface: valid/ready handshake with trigger index and found flag.
interface etsu_out_if;
    logic                         valid;
    logic                         ready;
    logic [etsu_pkg::INDEX_W-1:0] trigger_index;
    logic                         found;

    modport source (output valid, output trigger_index, output found, input ready);
    modport sink   (input valid, input trigger_index, input found, output ready);
endinterface

/* design/scope_edge_trigger_search_unit.sv */
// Top level of the scope edge trigger search unit: configuration registers and block wiring.
//
//   Channel    Direction  Handshake          Payload
//   i_cmd_ch   in         valid/ready        cmd, sample
//   o_res_ch   out        valid/ready        trigger_index, found (one word per search)
//   i_cfg_*    in         write enable only  i_cfg_idx, i_cfg_data
//
// A store word is accepted every cycle while the command queue has room, and is written
// into the sample ring when the back end takes it from the queue. A search makes one ring
// read per step over at most half the ring, set by the single port of the ring RAM, plus start and hand-off states.
// Reset is synchronous; a fill count stands in for clearing the ring, so no clearing pass.
// A two-word queue lets stores be accepted while a search runs; a stalled result holds
// the back end once its output register and hold state are full, then input once the queue fills.
module scope_edge_trigger_search_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    etsu_in_if.sink                          i_cmd_ch,
    etsu_out_if.source                       o_res_ch,
    input  logic                             i_cfg_we,
    input  logic [etsu_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [etsu_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [etsu_pkg::LEVEL_W-1:0] r_trigger_level;
    logic                         r_falling_edge;
    logic [etsu_pkg::VHW_W-1:0]   r_view_half_width;
    etsu_pkg::t_trig_cfg          trig_cfg;

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    etsu_pkg::t_cmd q_in;
    etsu_pkg::t_cmd q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_level   <= etsu_pkg::LEVEL_RESET;
            r_falling_edge    <= 1'b0;
            r_view_half_width <= etsu_pkg::VHW_RESET;
        end else if (i_cfg_we) begin
            case (etsu_pkg::t_reg_idx'(i_cfg_idx))
                etsu_pkg::REG_TRIGGER_LEVEL: begin
                    r_trigger_level <= i_cfg_data[etsu_pkg::LEVEL_W-1:0];
                end
                etsu_pkg::REG_FALLING_EDGE: begin
                    r_falling_edge <= i_cfg_data[0];
                end
                etsu_pkg::REG_VIEW_HALF_WIDTH: begin
                    r_view_half_width <= i_cfg_data[etsu_pkg::VHW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign trig_cfg.level   = r_trigger_level;
    assign trig_cfg.falling = r_falling_edge;

    etsu_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_ch          (i_cmd_ch),
        .i_view_half_width (r_view_half_width),
        .i_q_full          (q_full),
        .o_q_push          (q_push),
        .o_q_entry         (q_in)
    );

    etsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    etsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (trig_cfg),
        .i_q_valid (q_valid),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .o_res_ch  (o_res_ch)
    );

endmodule

/* design/etsu_ram.sv */
// Generic single-port RAM with registered read data.
module etsu_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/etsu_front.sv */
// Front end: accepts command words, tracks the newest sample index, classifies commands.
module etsu_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    etsu_in_if.sink                     i_cmd_ch,
    input  logic [etsu_pkg::VHW_W-1:0]  i_view_half_width,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output etsu_pkg::t_cmd              o_q_entry
);

    logic [etsu_pkg::ADDR_W-1:0] r_newest;
    logic [etsu_pkg::ADDR_W-1:0] n_newest;
    logic                        accept;

    assign i_cmd_ch.ready = !i_q_full;
    assign accept         = i_cmd_ch.valid && !i_q_full;
    assign o_q_push       = accept;

    always_comb begin
        n_newest            = r_newest;
        o_q_entry.search    = (i_cmd_ch.cmd == etsu_pkg::CMD_SEARCH);
        o_q_entry.sample    = i_cmd_ch.sample;
        // The store depth is a power of two, so index arithmetic wraps by itself.
        if (i_cmd_ch.cmd == etsu_pkg::CMD_SEARCH) begin
            o_q_entry.addr = r_newest - etsu_pkg::ADDR_W'(i_view_half_width);
        end else begin
            o_q_entry.addr = r_newest + etsu_pkg::ADDR_W'(1);
            if (accept) begin
                n_newest = o_q_entry.addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= etsu_pkg::ADDR_W'(etsu_pkg::BUFFER_DEPTH - 1);
        end else begin
            r_newest <= n_newest;
        end
    end

endmodule

/* design/etsu_fifo.sv */
// Short command queue between the front end and the back end.
module etsu_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  etsu_pkg::t_cmd i_entry,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output etsu_pkg::t_cmd o_entry
);

    etsu_pkg::t_cmd              r_mem [etsu_pkg::QUEUE_DEPTH];
    logic [etsu_pkg::QPTR_W-1:0] r_wptr;
    logic [etsu_pkg::QPTR_W-1:0] r_rptr;
    logic [etsu_pkg::QPTR_W:0]   r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_count == (etsu_pkg::QPTR_W + 1)'(etsu_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + etsu_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + etsu_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (etsu_pkg::QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (etsu_pkg::QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/etsu_back.sv */
// Back end: writes samples into the store and walks it backward for a trigger crossing.
module etsu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  etsu_pkg::t_trig_cfg i_cfg,
    input  logic                i_q_valid,
    input  etsu_pkg::t_cmd      i_q_entry,
    output logic                o_q_pop,
    etsu_out_if.source          o_res_ch
);

    etsu_pkg::t_back_state r_state, n_state;
    logic [etsu_pkg::ADDR_W-1:0]      r_cur, n_cur;
    logic [etsu_pkg::ADDR_W-1:0]      r_start, n_start;
    logic [etsu_pkg::STEP_W-1:0]      r_cnt, n_cnt;
    logic [etsu_pkg::SAMPLE_BITS-1:0] r_newer, n_newer;
    logic [etsu_pkg::FILL_W-1:0]      r_fill, n_fill;
    logic                             r_rd_live, n_rd_live;
    etsu_pkg::t_result                r_res, n_res;
    etsu_pkg::t_result                r_out;
    logic                             r_out_valid;
    logic                             out_load;

    logic                             ram_we;
    logic [etsu_pkg::ADDR_W-1:0]      ram_addr;
    logic [etsu_pkg::SAMPLE_BITS-1:0] ram_rdata;
    logic [etsu_pkg::SAMPLE_BITS-1:0] older;
    logic                             hit;

    etsu_ram #(
        .WIDTH (etsu_pkg::SAMPLE_BITS),
        .DEPTH (etsu_pkg::BUFFER_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_q_entry.sample),
        .o_rdata (ram_rdata)
    );

    // Stores fill the ring in index order from zero after reset, so every entry
    // at or above the fill count is unwritten since reset and is read as zero.
    assign older = r_rd_live ? ram_rdata : '0;

    always_comb begin
        if (i_cfg.falling) begin
            hit = ({4'b0, r_newer} < {4'b0, i_cfg.level})
                && ({4'b0, older} >= {4'b0, i_cfg.level});
        end else begin
            hit = ({4'b0, r_newer} >= {4'b0, i_cfg.level})
                && ({4'b0, older} < {4'b0, i_cfg.level});
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_start  = r_start;
        n_cnt    = r_cnt;
        n_newer  = r_newer;
        n_fill   = r_fill;
        n_res    = r_res;
        o_q_pop  = 1'b0;
        ram_we   = 1'b0;
        ram_addr = r_cur - etsu_pkg::ADDR_W'(1);
        out_load = 1'b0;
        case (r_state)
            etsu_pkg::ST_IDLE: begin
                ram_addr = i_q_entry.addr;
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_entry.search) begin
                        n_cur   = i_q_entry.addr;
                        n_start = i_q_entry.addr;
                        n_state = etsu_pkg::ST_FIRST;
                    end else begin
                        ram_we = 1'b1;
                        if (r_fill != etsu_pkg::FILL_W'(etsu_pkg::BUFFER_DEPTH)) begin
                            n_fill = r_fill + etsu_pkg::FILL_W'(1);
                        end
                    end
                end
            end
            etsu_pkg::ST_FIRST: begin
                // Start sample arrives; fetch its older neighbor next.
                n_newer = older;
                n_cnt   = etsu_pkg::STEP_W'(etsu_pkg::HALF_STEPS - 1);
                n_state = etsu_pkg::ST_WALK;
            end
            etsu_pkg::ST_WALK: begin
                ram_addr = r_cur - etsu_pkg::ADDR_W'(2);
                if (hit) begin
                    n_res.trigger_index = etsu_pkg::INDEX_W'(r_cur);
                    n_res.found         = 1'b1;
                    n_state             = etsu_pkg::ST_HOLD;
                end else if (r_cnt == '0) begin
                    n_res.trigger_index = etsu_pkg::INDEX_W'(r_start);
                    n_res.found         = 1'b0;
                    n_state             = etsu_pkg::ST_HOLD;
                end else begin
                    n_cur   = r_cur - etsu_pkg::ADDR_W'(1);
                    n_newer = older;
                    n_cnt   = r_cnt - etsu_pkg::STEP_W'(1);
                end
            end
            etsu_pkg::ST_HOLD: begin
                if (!r_out_valid || o_res_ch.ready) begin
                    out_load = 1'b1;
                    n_state  = etsu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = etsu_pkg::ST_IDLE;
            end
        endcase
        n_rd_live = ({1'b0, ram_addr} < r_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= etsu_pkg::ST_IDLE;
            r_fill      <= '0;
            r_rd_live   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_rd_live <= n_rd_live;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_start <= n_start;
        r_cnt   <= n_cnt;
        r_newer <= n_newer;
        r_res   <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_res_ch.valid         = r_out_valid;
    assign o_res_ch.trigger_index = r_out.trigger_index;
    assign o_res_ch.found         = r_out.found;

endmodule

/* design/etsu_checker.sv */
// Port-level checks for the scope edge trigger search unit, bound to the top level.
module etsu_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [etsu_pkg::INDEX_W-1:0] i_out_index,
    input logic                         i_out_found
);

    // No result word may be left over from before a reset.
    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // The command queue is empty after reset, so the block must take words.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("command channel not ready after reset");

    // A stalled result word keeps its value until taken.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_index) && $stable(i_out_found)))
        else $error("stalled result word changed");

endmodule

bind scope_edge_trigger_search_unit etsu_checker u_etsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_cmd_ch.ready),
    .i_out_valid (o_res_ch.valid),
    .i_out_ready (o_res_ch.ready),
    .i_out_index (o_res_ch.trigger_index),
    .i_out_found (o_res_ch.found)
);

/* sim/tb_scope_edge_trigger_search_unit.sv */
// Self-checking testbench for the scope edge trigger search unit.
`timescale 1ns / 1ps

module tb_scope_edge_trigger_search_unit;
    import etsu_pkg::*;

    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 7;
    localparam int PHASE_WORDS   = 160;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    localparam t_result UNTYPED = '0;

    typedef enum int {
        WAVE_NOISE,
        WAVE_SQUARE,
        WAVE_FLAT,
        WAVE_NEAR,
        WAVE_RAMP
    } t_wave;

    typedef struct {
        bit                    is_cfg;
        t_reg_idx              reg_sel;
        logic [CFG_DATA_W-1:0] value;
        t_cmd_code             cmd;
        bit                    typed;
        t_result               want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    etsu_in_if  cmd_ch();
    etsu_out_if res_ch();

    scope_edge_trigger_search_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_ch   (cmd_ch),
        .o_res_ch   (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Local copy of the sample ring, pointer and trigger settings.
    logic [SAMPLE_BITS-1:0] ring_model [BUFFER_DEPTH];
    logic [ADDR_W-1:0]      newest_model;
    logic [LEVEL_W-1:0]     level_model;
    logic                   falling_model;
    logic [VHW_W-1:0]       vhw_model;

    t_result crossing_q[$];
    int      err_cnt      = 0;
    int      cycle_cnt    = 0;
    bit      no_idle      = 1'b0;
    bit      hold_off_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void clear_model();
        foreach (ring_model[n]) ring_model[n] = '0;
        newest_model  = ADDR_W'(BUFFER_DEPTH - 1);
        level_model   = LEVEL_RESET;
        falling_model = 1'b0;
        vhw_model     = VHW_RESET;
    endfunction

    // Walk back from the view start over half the ring looking for a level crossing.
    function automatic t_result find_crossing();
        logic [ADDR_W-1:0]      start_pos;
        logic [ADDR_W-1:0]      pos;
        logic [ADDR_W-1:0]      older_pos;
        logic [SAMPLE_BITS-1:0] newer_s;
        logic [SAMPLE_BITS-1:0] older_s;
        bit                     hit;
        t_result                r;
        start_pos = newest_model - ADDR_W'(vhw_model);
        pos       = start_pos;
        hit       = 1'b0;
        for (int k = 0; k < HALF_STEPS && !hit; k++) begin
            older_pos = pos - 1'b1;
            newer_s   = ring_model[pos];
            older_s   = ring_model[older_pos];
            if (!falling_model)
                hit = (newer_s >= level_model) && (older_s < level_model);
            else
                hit = (newer_s < level_model) && (older_s >= level_model);
            if (!hit)
                pos = older_pos;
        end
        r.trigger_index = INDEX_W'(hit ? pos : start_pos);
        r.found         = hit;
        return r;
    endfunction

    task automatic put_word(input t_cmd_code c, input logic [SAMPLE_BITS-1:0] smp,
                            input bit typed, input t_result want);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.cmd    <= c;
        cmd_ch.sample <= smp;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        if (c == CMD_STORE) begin
            newest_model             = newest_model + 1'b1;
            ring_model[newest_model] = smp;
        end else begin
            crossing_q.push_back(typed ? want : find_crossing());
        end
    endtask

    // Stores produce no word, so give them time to land in the ring after the last result.
    task automatic drain_searches();
        cmd_ch.valid <= 1'b0;
        while (crossing_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx r, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (r)
            REG_TRIGGER_LEVEL:   level_model   = d[LEVEL_W-1:0];
            REG_FALLING_EDGE:    falling_model = d[0];
            REG_VIEW_HALF_WIDTH: vhw_model     = d[VHW_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Bursts of shaped samples, each followed by one or a few searches.
    task automatic random_phase(input int n_items);
        int                     sent;
        int                     len;
        int                     period;
        int                     k;
        int                     v;
        t_wave                  wave;
        logic [SAMPLE_BITS-1:0] base_val;
        logic [SAMPLE_BITS-1:0] smp;
        sent = 0;
        while (sent < n_items) begin
            len      = ($urandom_range(19) == 0) ? $urandom_range(300, 64) : $urandom_range(16, 0);
            wave     = t_wave'($urandom_range(4));
            period   = $urandom_range(20, 1);
            base_val = SAMPLE_BITS'($urandom_range(4095));
            for (int j = 0; j < len && sent < n_items; j++) begin
                case (wave)
                    WAVE_NOISE:  smp = SAMPLE_BITS'($urandom_range(4095));
                    WAVE_SQUARE: begin
                        if ((j / period) % 2)
                            smp = SAMPLE_BITS'($urandom_range(4095, level_model));
                        else if (level_model == 0)
                            smp = '0;
                        else
                            smp = SAMPLE_BITS'($urandom_range(level_model - 1, 0));
                    end
                    WAVE_FLAT:   smp = base_val;
                    WAVE_NEAR: begin
                        v   = int'(level_model) + int'($urandom_range(2)) - 1;
                        smp = (v < 0) ? '0 : (v > 4095) ? SAMPLE_MAX : SAMPLE_BITS'(v);
                    end
                    default:     smp = base_val + SAMPLE_BITS'(j * period);
                endcase
                put_word(CMD_STORE, smp, 1'b0, UNTYPED);
                sent++;
            end
            k = ($urandom_range(7) == 0) ? $urandom_range(3, 2) : 1;
            repeat (k) begin
                put_word(CMD_SEARCH, SAMPLE_BITS'($urandom_range(4095)), 1'b0, UNTYPED);
                sent++;
            end
        end
    endtask

    // Result side: random back-pressure, one long hold-off on request, and the checks.
    initial begin
        int      hold_left;
        t_result exp_r;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                if (crossing_q.size() == 0) begin
                    $error("result word with no search outstanding: trigger_index %0d found %0d",
                           res_ch.trigger_index, res_ch.found);
                    err_cnt++;
                end else begin
                    exp_r = crossing_q.pop_front();
                    if (res_ch.trigger_index !== exp_r.trigger_index) begin
                        $error("trigger_index: expected %0d, actual %0d",
                               exp_r.trigger_index, res_ch.trigger_index);
                        err_cnt++;
                    end
                    if (res_ch.found !== exp_r.found) begin
                        $error("found: expected %0d, actual %0d", exp_r.found, res_ch.found);
                        err_cnt++;
                    end
                end
            end
            if (hold_off_req) begin
                hold_left    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        t_dir_row           rows[$];
        logic [LEVEL_W-1:0] lvl;
        logic               fall;
        logic [VHW_W-1:0]   vhw;

        cmd_ch.valid  <= 1'b0;
        cmd_ch.cmd    <= CMD_STORE;
        cmd_ch.sample <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_TRIGGER_LEVEL;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        clear_model();

        // Reset contents and settings first, then the level and width extremes and both edges.
        rows = '{
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b1, '{11'd1983, 1'b0}},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd4095, CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b1, '{11'd1984, 1'b0}},
            '{1'b1, REG_VIEW_HALF_WIDTH, 12'd0,    CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b1, '{11'd0, 1'b1}},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd2047, CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd2048, CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b1, '{11'd2, 1'b1}},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd4095, CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b0, UNTYPED},
            '{1'b1, REG_FALLING_EDGE,    12'd1,    CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b1, '{11'd4, 1'b1}},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd2047, CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b0, UNTYPED},
            '{1'b1, REG_TRIGGER_LEVEL,   12'd0,    CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b1, '{11'd5, 1'b0}},
            '{1'b1, REG_FALLING_EDGE,    12'd0,    CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b1, '{11'd5, 1'b0}},
            '{1'b1, REG_TRIGGER_LEVEL,   12'd4095, CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd4094, CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd4095, CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b1, '{11'd7, 1'b1}},
            '{1'b1, REG_VIEW_HALF_WIDTH, 12'd1023, CMD_STORE,  1'b0, UNTYPED},
            '{1'b1, REG_FALLING_EDGE,    12'd1,    CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b1, '{11'd1032, 1'b0}},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_STORE,  1'b0, UNTYPED},
            '{1'b0, REG_TRIGGER_LEVEL,   12'd0,    CMD_SEARCH, 1'b0, UNTYPED}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[n]) begin
            if (rows[n].is_cfg) begin
                drain_searches();
                write_reg(rows[n].reg_sel, rows[n].value);
            end else begin
                put_word(rows[n].cmd, rows[n].value[SAMPLE_BITS-1:0], rows[n].typed, rows[n].want);
            end
        end

        // Crossing right at the newest sample keeps searches short, so the result side
        // backs up while the receiver holds off and the command channel stalls.
        drain_searches();
        write_reg(REG_TRIGGER_LEVEL, CFG_DATA_W'(2048));
        write_reg(REG_FALLING_EDGE, '0);
        write_reg(REG_VIEW_HALF_WIDTH, '0);
        put_word(CMD_STORE, '0, 1'b0, UNTYPED);
        put_word(CMD_STORE, SAMPLE_MAX, 1'b0, UNTYPED);
        hold_off_req = 1'b1;
        repeat (24) put_word(CMD_SEARCH, SAMPLE_BITS'($urandom_range(4095)), 1'b0, UNTYPED);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin
                    lvl  = '1;
                    fall = 1'b1;
                    vhw  = '1;
                end
                1: begin
                    lvl  = '0;
                    fall = 1'b0;
                    vhw  = '0;
                end
                default: begin
                    case ($urandom_range(3))
                        0:       lvl = '0;
                        1:       lvl = '1;
                        default: lvl = LEVEL_W'($urandom_range(4095));
                    endcase
                    fall = 1'($urandom_range(1));
                    case ($urandom_range(3))
                        0:       vhw = '1;
                        1:       vhw = VHW_W'($urandom_range(16));
                        default: vhw = VHW_W'($urandom_range(1023));
                    endcase
                end
            endcase
            no_idle = (p == 3);
            drain_searches();
            write_reg(REG_TRIGGER_LEVEL, CFG_DATA_W'(lvl));
            write_reg(REG_FALLING_EDGE, CFG_DATA_W'(fall));
            write_reg(REG_VIEW_HALF_WIDTH, CFG_DATA_W'(vhw));
            random_phase(PHASE_WORDS);
        end

        no_idle = 1'b0;
        drain_searches();
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
